// ===== hw/rtl/tt_pkg.sv =====
// ----------------------------------------------------------------------------
// tt_pkg: shared types and constants of the text token tagger
// code point constants, character class bundle, token word and queue sizing
// ----------------------------------------------------------------------------
package tt_pkg;

   localparam int CP_W   = 21;
   localparam int OFS_W  = 16;
   localparam int LEN_W  = 3;

   // named code points
   localparam logic [CP_W-1:0] CP_TAB    = 21'h00009;
   localparam logic [CP_W-1:0] CP_LF     = 21'h0000A;
   localparam logic [CP_W-1:0] CP_CR     = 21'h0000D;
   localparam logic [CP_W-1:0] CP_SPACE  = 21'h00020;
   localparam logic [CP_W-1:0] CP_HYPHEN = 21'h0002D;
   localparam logic [CP_W-1:0] CP_SLASH  = 21'h0002F;
   localparam logic [CP_W-1:0] CP_NBSP   = 21'h000A0;
   localparam logic [CP_W-1:0] CP_SHY    = 21'h000AD;
   localparam logic [CP_W-1:0] CP_ZWSP   = 21'h0200B;
   localparam logic [CP_W-1:0] CP_ZWJ    = 21'h0200D;
   localparam logic [CP_W-1:0] CP_NNBSP  = 21'h0202F;
   localparam logic [CP_W-1:0] CP_RI_LO  = 21'h1F1E6;
   localparam logic [CP_W-1:0] CP_RI_HI  = 21'h1F1FF;

   // output queue sizing
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic nl;        // line feed after cr mapping
      logic white;
      logic invis;
      logic comb;
      logic ri;        // regional indicator
      logic cjk;
      logic closing;   // closing punctuation
      logic brk;       // own break opportunity
      logic zwj;
   } tt_class_type;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [OFS_W-1:0] byte_start;
      logic [OFS_W-1:0] byte_end;
      logic             is_newline;
      logic             is_white;
      logic             is_invisible;
      logic             is_combining;
      logic             joins_cluster;
      logic             break_after;
      logic             last_token;
   } tt_token_type;

   // up to two tokens pushed per processed item, first one written first
   typedef struct packed {
      logic [1:0]   count;
      tt_token_type first;
      tt_token_type second;
   } tt_push_type;

endpackage

// ===== hw/rtl/tt_classify.sv =====
// ----------------------------------------------------------------------------
// tt_classify: character class decode
// range and equality compares of one code point into the class bundle
// ----------------------------------------------------------------------------
module tt_classify (
   input  logic [tt_pkg::CP_W-1:0] cp,
   output tt_pkg::tt_class_type    cls
);

   logic white;
   logic mark;
   logic vs;
   logic modifier;
   logic closing;

   always_comb begin
      white = (cp == tt_pkg::CP_TAB) || (cp == tt_pkg::CP_SPACE) ||
              (cp == tt_pkg::CP_NBSP) || (cp == 21'h01680) ||
              (cp >= 21'h02000 && cp <= 21'h0200A) || (cp == tt_pkg::CP_NNBSP) ||
              (cp == 21'h0205F) || (cp == 21'h03000);
      mark  = (cp >= 21'h00300 && cp <= 21'h0036F) || (cp >= 21'h01AB0 && cp <= 21'h01AFF) ||
              (cp >= 21'h01DC0 && cp <= 21'h01DFF) || (cp >= 21'h020D0 && cp <= 21'h020FF) ||
              (cp >= 21'h0FE20 && cp <= 21'h0FE2F);
      vs    = (cp >= 21'h0FE00 && cp <= 21'h0FE0F) || (cp >= 21'hE0100 && cp <= 21'hE01EF);
      modifier = (cp >= 21'h1F3FB && cp <= 21'h1F3FF);
      unique case (cp)
         21'h00029, 21'h0005D, 21'h0007D, 21'h0002C, 21'h0002E,
         21'h00021, 21'h0003F, 21'h0003A, 21'h0003B,
         21'h03001, 21'h03002, 21'h0FF01, 21'h0FF09, 21'h0FF0C,
         21'h0FF0E, 21'h0FF1A, 21'h0FF1B, 21'h0FF1F: closing = 1'b1;
         default:                                    closing = 1'b0;
      endcase

      cls.nl      = (cp == tt_pkg::CP_LF);
      cls.white   = white;
      cls.zwj     = (cp == tt_pkg::CP_ZWJ);
      cls.comb    = mark || vs || modifier || (cp == tt_pkg::CP_ZWJ);
      cls.invis   = (cp == tt_pkg::CP_ZWSP) || (cp == tt_pkg::CP_SHY) ||
                    (cp == tt_pkg::CP_ZWJ) || vs;
      cls.ri      = (cp >= tt_pkg::CP_RI_LO) && (cp <= tt_pkg::CP_RI_HI);
      cls.cjk     = (cp >= 21'h02E80 && cp <= 21'h0A4CF) || (cp >= 21'h0AC00 && cp <= 21'h0D7AF) ||
                    (cp >= 21'h0F900 && cp <= 21'h0FAFF) || (cp >= 21'h20000 && cp <= 21'h323AF);
      cls.closing = closing;
      // no-break spaces never offer a break
      cls.brk     = (white && (cp != tt_pkg::CP_NBSP) && (cp != tt_pkg::CP_NNBSP)) ||
                    (cp == tt_pkg::CP_HYPHEN) || (cp == tt_pkg::CP_SLASH) ||
                    (cp == tt_pkg::CP_SHY) || (cp == tt_pkg::CP_ZWSP);
   end

endmodule

// ===== hw/rtl/tt_core.sv =====
// ----------------------------------------------------------------------------
// tt_core: input register, one-token delay and tagging state
// forms the tokens of one item in a single pass and pushes them to the queue
// ----------------------------------------------------------------------------
module tt_core #(
   parameter longint unsigned MAX_TEXT_BYTES = 65535
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [tt_pkg::CP_W-1:0]  req_code_point,
   input  logic [tt_pkg::LEN_W-1:0] req_byte_len,
   input  logic                     req_end_of_text,
   input  logic                     room,
   output tt_pkg::tt_push_type      push
);

   localparam logic [tt_pkg::OFS_W-1:0] LIMIT =
      (MAX_TEXT_BYTES < 64'd65535) ? tt_pkg::OFS_W'(MAX_TEXT_BYTES) : 16'hFFFF;

   // input register
   logic                     in_valid_ff, in_valid_in;
   logic [tt_pkg::CP_W-1:0]  in_cp_ff;
   logic [tt_pkg::LEN_W-1:0] in_len_ff;
   logic                     in_eot_ff;

   // tagging state
   logic                     pend_valid_ff, pend_valid_in;
   logic [tt_pkg::CP_W-1:0]  pend_cp_ff, pend_cp_in;
   logic [tt_pkg::OFS_W-1:0] pend_bs_ff, pend_bs_in;
   logic [tt_pkg::OFS_W-1:0] pend_be_ff, pend_be_in;
   tt_pkg::tt_class_type     pend_cls_ff, pend_cls_in;
   logic                     pend_join_ff, pend_join_in;
   logic                     prev_cr_ff, prev_cr_in;
   logic                     rodd_ff, rodd_in;
   logic [tt_pkg::OFS_W-1:0] offset_ff, offset_in;

   logic                     advance;
   logic                     req_fire;
   logic [tt_pkg::OFS_W:0]   sum;
   logic [tt_pkg::OFS_W-1:0] end_ofs;
   logic [tt_pkg::CP_W-1:0]  cp;
   tt_pkg::tt_class_type     cls;
   logic                     merge;
   logic                     joins;
   tt_pkg::tt_token_type     pend_tok;
   tt_pkg::tt_token_type     new_tok;

   assign advance   = in_valid_ff && room;
   assign req_ready = !in_valid_ff || room;
   assign req_fire  = req_valid && req_ready;
   assign in_valid_in = req_fire || (in_valid_ff && !advance);

   assign cp = (in_cp_ff == tt_pkg::CP_CR) ? tt_pkg::CP_LF : in_cp_ff;

   tt_classify u_classify (
      .cp  (cp),
      .cls (cls)
   );

   always_comb begin
      sum     = {1'b0, offset_ff} + (tt_pkg::OFS_W + 1)'(in_len_ff);
      end_ofs = (sum > {1'b0, LIMIT}) ? LIMIT : sum[tt_pkg::OFS_W-1:0];
      merge   = (in_cp_ff == tt_pkg::CP_LF) && prev_cr_ff && pend_valid_ff &&
                (pend_cp_ff == tt_pkg::CP_LF);
      joins   = pend_valid_ff && !cls.nl && !pend_cls_ff.nl &&
                (cls.comb || pend_cls_ff.zwj || (pend_cls_ff.ri && cls.ri && rodd_ff));

      // pending token as it leaves, break from its own class plus the cjk rule
      pend_tok.code_point    = pend_cp_ff;
      pend_tok.byte_start    = pend_bs_ff;
      pend_tok.byte_end      = merge ? end_ofs : pend_be_ff;
      pend_tok.is_newline    = pend_cls_ff.nl;
      pend_tok.is_white      = pend_cls_ff.white;
      pend_tok.is_invisible  = pend_cls_ff.invis;
      pend_tok.is_combining  = pend_cls_ff.comb;
      pend_tok.joins_cluster = pend_join_ff;
      pend_tok.break_after   = pend_cls_ff.brk ||
                               (!merge && pend_cls_ff.cjk && !cls.nl && !cls.comb &&
                                !cls.closing);
      pend_tok.last_token    = merge;

      // token of this item, leaves only when it closes the text
      new_tok.code_point    = cp;
      new_tok.byte_start    = offset_ff;
      new_tok.byte_end      = end_ofs;
      new_tok.is_newline    = cls.nl;
      new_tok.is_white      = cls.white;
      new_tok.is_invisible  = cls.invis;
      new_tok.is_combining  = cls.comb;
      new_tok.joins_cluster = joins;
      new_tok.break_after   = cls.brk;
      new_tok.last_token    = 1'b1;

      pend_valid_in = pend_valid_ff;
      pend_cp_in    = pend_cp_ff;
      pend_bs_in    = pend_bs_ff;
      pend_be_in    = pend_be_ff;
      pend_cls_in   = pend_cls_ff;
      pend_join_in  = pend_join_ff;
      prev_cr_in    = prev_cr_ff;
      rodd_in       = rodd_ff;
      offset_in     = offset_ff;
      push.count    = 2'd0;
      push.first    = pend_tok;
      push.second   = new_tok;

      if (advance) begin
         offset_in = end_ofs;
         if (merge) begin
            // lf after cr only stretches the folded newline token
            pend_be_in = end_ofs;
            prev_cr_in = 1'b0;
            if (in_eot_ff) begin
               push.count = 2'd1;
            end
         end else begin
            prev_cr_in = (in_cp_ff == tt_pkg::CP_CR);
            if (pend_valid_ff) begin
               push.count = in_eot_ff ? 2'd2 : 2'd1;
               rodd_in    = joins ? (rodd_ff ^ cls.ri) : cls.ri;
            end else begin
               push.count = in_eot_ff ? 2'd1 : 2'd0;
               push.first = new_tok;
               rodd_in    = cls.ri;
            end
            pend_valid_in = 1'b1;
            pend_cp_in    = cp;
            pend_bs_in    = offset_ff;
            pend_be_in    = end_ofs;
            pend_cls_in   = cls;
            pend_join_in  = joins;
         end
         if (in_eot_ff) begin
            // text closed, next item opens a new text
            pend_valid_in = 1'b0;
            prev_cr_in    = 1'b0;
            rodd_in       = 1'b0;
            offset_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         prev_cr_ff    <= 1'b0;
         rodd_ff       <= 1'b0;
         offset_ff     <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         pend_valid_ff <= pend_valid_in;
         prev_cr_ff    <= prev_cr_in;
         rodd_ff       <= rodd_in;
         offset_ff     <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_cp_ff  <= req_code_point;
         in_len_ff <= req_byte_len;
         in_eot_ff <= req_end_of_text;
      end
      pend_cp_ff   <= pend_cp_in;
      pend_bs_ff   <= pend_bs_in;
      pend_be_ff   <= pend_be_in;
      pend_cls_ff  <= pend_cls_in;
      pend_join_ff <= pend_join_in;
   end

   // a held cr always sits in front of its own pending newline token
   a_cr_pending: assert property (@(posedge clock) disable iff (reset)
      prev_cr_ff |-> (pend_valid_ff && pend_cls_ff.nl))
      else $error("cr flag without pending newline token");

   // a closed text leaves nothing behind
   a_eot_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && in_eot_ff) |=> (!pend_valid_ff && offset_ff == '0 && !prev_cr_ff))
      else $error("state not cleared after end of text");

   // the byte offset never passes the saturation limit
   a_offset_limit: assert property (@(posedge clock) disable iff (reset)
      offset_ff <= LIMIT)
      else $error("byte offset beyond limit");

endmodule

// ===== hw/rtl/tt_queue.sv =====
// ----------------------------------------------------------------------------
// tt_queue: output token queue
// takes up to two tokens a cycle; while out_ready is high, hands out one word a cycle
// ----------------------------------------------------------------------------
module tt_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  tt_pkg::tt_push_type  push,
   output logic                 room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output tt_pkg::tt_token_type out_token
);

   tt_pkg::tt_token_type mem [tt_pkg::Q_DEPTH];

   logic [tt_pkg::Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [tt_pkg::Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [tt_pkg::Q_CNT_W-1:0] count_ff, count_in;
   logic [tt_pkg::Q_PTR_W-1:0] wr_next;
   logic                       pop;

   assign out_valid = (count_ff != '0);
   assign out_token = mem[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign room      = (count_ff <= tt_pkg::Q_CNT_W'(tt_pkg::Q_DEPTH - 2));
   assign wr_next   = wr_ptr_ff + tt_pkg::Q_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + tt_pkg::Q_PTR_W'(push.count);
      rd_ptr_in = rd_ptr_ff + tt_pkg::Q_PTR_W'(pop);
      count_in  = count_ff + tt_pkg::Q_CNT_W'(push.count) - tt_pkg::Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem[wr_next] <= push.second;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push.count != 2'd0) |-> (count_ff <= tt_pkg::Q_CNT_W'(tt_pkg::Q_DEPTH) -
                                tt_pkg::Q_CNT_W'(push.count)))
      else $error("queue overflow");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && push.count == 2'd0) |=>
         (count_ff == $past(count_ff) - tt_pkg::Q_CNT_W'(1)))
      else $error("queue count did not drop on pop");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= tt_pkg::Q_CNT_W'(tt_pkg::Q_DEPTH))
      else $error("queue count out of range");

endmodule

// ===== hw/rtl/text_token_tagger.sv =====
// ----------------------------------------------------------------------------
// text_token_tagger: line break and grapheme cluster token tagger
// one decoded code point per word in, one tagged token per word out
// ----------------------------------------------------------------------------
//
//   channel  | ports                                   | word
//   ---------+-----------------------------------------+---------------------------
//   request  | req_valid / req_ready                   | code point, byte length,
//            |                                         | end of text
//   response | rsp_valid / rsp_ready                   | token code point, byte
//            |                                         | range, class flags, break,
//            |                                         | cluster join, last token
//
// - one request word per cycle while the queue has room; the token of a word leaves
//   one word late, and the end-of-text word flushes the last one (up to two tokens)
// - tokens formed from a request word pass from the input register into the queue
//   once it has room, and are taken from rsp_ out of the queue
// - the rate is set by the four-entry output queue: the input register hands
//   its word on while the queue holds at most two tokens
// - synchronous active-high reset clears pointers, counts and text state
// - rsp_ready low fills the queue, then req_ready drops; nothing is lost
//
module text_token_tagger #(
   parameter longint unsigned MAX_TEXT_BYTES = 65535
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [20:0] req_code_point,
   input  logic [2:0]  req_byte_len,
   input  logic        req_end_of_text,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_out_code_point,
   output logic [15:0] rsp_byte_start,
   output logic [15:0] rsp_byte_end,
   output logic        rsp_is_newline,
   output logic        rsp_is_white,
   output logic        rsp_is_invisible,
   output logic        rsp_is_combining,
   output logic        rsp_joins_cluster,
   output logic        rsp_break_after,
   output logic        rsp_last_token
);

   // tokens formed per processed word
   tt_pkg::tt_push_type  push;
   // queue can take a full two-token push
   logic                 room;
   tt_pkg::tt_token_type token;

   // input register, cr/lf folding, cluster and break tagging
   tt_core #(
      .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
   ) u_core (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_code_point  (req_code_point),
      .req_byte_len    (req_byte_len),
      .req_end_of_text (req_end_of_text),
      .room            (room),
      .push            (push)
   );

   // output queue, decouples the response side from the tagger
   tt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_token (token)
   );

   // unpack the token word onto the response ports
   assign rsp_out_code_point = token.code_point;
   assign rsp_byte_start     = token.byte_start;
   assign rsp_byte_end       = token.byte_end;
   assign rsp_is_newline     = token.is_newline;
   assign rsp_is_white       = token.is_white;
   assign rsp_is_invisible   = token.is_invisible;
   assign rsp_is_combining   = token.is_combining;
   assign rsp_joins_cluster  = token.joins_cluster;
   assign rsp_break_after    = token.break_after;
   assign rsp_last_token     = token.last_token;

endmodule
